>>> rtl/core/eida_pkg.sv
// ----------------------------------------------------------------------------
// eida_pkg
// Shared types and codes of the identifier allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package eida_pkg;

  localparam int unsigned IdFieldW = 8;
  localparam int unsigned StatusW  = 2;

  typedef enum logic {
    CMD_CREATE = 1'b0,
    CMD_KILL   = 1'b1
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_CREATED = 2'd0,
    ST_KILLED  = 2'd1,
    ST_IGNORED = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [IdFieldW-1:0] result_id;
    status_e             status;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/eida_if.sv
// ----------------------------------------------------------------------------
// eida_req_if / eida_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface eida_req_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] kill_id;

  modport source (output valid, output cmd, output kill_id, input ready);
  modport sink   (input valid, input cmd, input kill_id, output ready);
endinterface

interface eida_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_id;
  logic [1:0] status;

  modport source (output valid, output result_id, output status, input ready);
  modport sink   (input valid, input result_id, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/entity_id_allocator_unit.sv
// ----------------------------------------------------------------------------
// entity_id_allocator_unit
// Identifier allocator: LIFO free stack in RAM, high-water counter for fresh
// identifiers, alive marks in RAM.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                       handshake
//  req_i    in   cmd, kill_id                  valid / ready
//  rsp_o    out  result_id, status             valid / ready
//
// On accept the block issues the RAM reads (free stack top, alive mark) and
// enters its execute state, which does the update and loads the response
// register once that register is free; the state RAMs return registered read
// data. No new request is taken before the current response is loaded.
// A new request is taken while a response still waits; a stalled response
// holds the block in its execute state.
// Reset is immediate: alive marks need no clearing pass, since an identifier
// at or above the high-water counter is never alive and every one below it
// has had its mark written.
// ----------------------------------------------------------------------------
`default_nettype none

module entity_id_allocator_unit
  import eida_pkg::*;
#(
  parameter int unsigned MAX_IDS = 256
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  eida_req_if.sink   req_i,
  eida_rsp_if.source rsp_o
);

  localparam int unsigned IdW  = $clog2(MAX_IDS);
  localparam int unsigned CntW = $clog2(MAX_IDS + 1);
  localparam int unsigned CmpW = (CntW > IdFieldW) ? CntW : IdFieldW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_IDS);
  localparam logic [CmpW-1:0] MaxCmp = CmpW'(MAX_IDS);

  state_e state_q, state_d;
  logic [CntW-1:0] free_count_q, free_count_d;
  logic [CntW-1:0] next_fresh_q, next_fresh_d;
  logic                cmd_q;
  logic [IdFieldW-1:0] eid_q;

  logic            accept;
  logic            out_free, out_load;
  rsp_t            rsp;

  logic            stack_we, alive_we;
  logic [IdW-1:0]  stack_waddr, alive_waddr, alive_raddr, stack_raddr;
  logic [IdW-1:0]  stack_wdata, stack_rdata;
  logic            alive_wdata, alive_rdata;

  logic [CmpW-1:0] eid_ext;
  logic            eid_alive;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  assign alive_raddr = IdW'(req_i.kill_id);
  assign stack_raddr = IdW'(free_count_q - CntW'(1));

  assign eid_ext   = CmpW'(eid_q);
  assign eid_alive = (eid_ext < MaxCmp) && (eid_ext < CmpW'(next_fresh_q)) && alive_rdata;

  always_comb begin
    state_d      = state_q;
    free_count_d = free_count_q;
    next_fresh_d = next_fresh_q;
    out_load     = 1'b0;
    stack_we     = 1'b0;
    stack_waddr  = IdW'(free_count_q);
    stack_wdata  = IdW'(eid_q);
    alive_we     = 1'b0;
    alive_waddr  = IdW'(eid_q);
    alive_wdata  = 1'b0;
    rsp.result_id = eid_q;
    rsp.status    = ST_IGNORED;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_q == CMD_CREATE) begin
          alive_wdata = 1'b1;
          if (free_count_q != '0) begin
            rsp.result_id = IdFieldW'(stack_rdata);
            rsp.status    = ST_CREATED;
            alive_waddr   = stack_rdata;
            alive_we      = 1'b1;
            free_count_d  = free_count_q - CntW'(1);
          end else if (next_fresh_q < MaxCnt) begin
            rsp.result_id = IdFieldW'(next_fresh_q);
            rsp.status    = ST_CREATED;
            alive_waddr   = IdW'(next_fresh_q);
            alive_we      = 1'b1;
            next_fresh_d  = next_fresh_q + CntW'(1);
          end else begin
            rsp.result_id = '0;
            rsp.status    = ST_FULL;
          end
        end else if (eid_alive) begin
          rsp.status = ST_KILLED;
          alive_we   = 1'b1;
          if (free_count_q < MaxCnt) begin
            stack_we     = 1'b1;
            free_count_d = free_count_q + CntW'(1);
          end
        end

        // hold everything until the response register can take the result
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end else begin
          free_count_d = free_count_q;
          next_fresh_d = next_fresh_q;
          stack_we     = 1'b0;
          alive_we     = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      free_count_q <= '0;
      next_fresh_q <= '0;
    end else begin
      state_q      <= state_d;
      free_count_q <= free_count_d;
      next_fresh_q <= next_fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= req_i.cmd;
      eid_q <= req_i.kill_id;
    end
  end

  eida_ram #(
    .Width (IdW),
    .Depth (MAX_IDS)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (stack_waddr),
    .wdata_i (stack_wdata),
    .re_i    (accept),
    .raddr_i (stack_raddr),
    .rdata_o (stack_rdata)
  );

  eida_ram #(
    .Width (1),
    .Depth (MAX_IDS)
  ) u_alive_ram (
    .clk_i   (clk_i),
    .we_i    (alive_we),
    .waddr_i (alive_waddr),
    .wdata_i (alive_wdata),
    .re_i    (accept),
    .raddr_i (alive_raddr),
    .rdata_o (alive_rdata)
  );

  eida_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (out_load),
    .rsp_i  (rsp),
    .free_o (out_free),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/eida_ram.sv
// ----------------------------------------------------------------------------
// eida_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module eida_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/eida_out_reg.sv
// ----------------------------------------------------------------------------
// eida_out_reg
// Response holding register in front of the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module eida_out_reg
  import eida_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire rsp_t       rsp_i,
  output logic            free_o,
  eida_rsp_if.source      rsp_o
);

  logic valid_q, valid_d;
  rsp_t rsp_q;

  assign free_o = !valid_q || rsp_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign rsp_o.valid     = valid_q;
  assign rsp_o.result_id = rsp_q.result_id;
  assign rsp_o.status    = rsp_q.status;

endmodule

`default_nettype wire
